// ===== hw/rtl/tlsc_pkg.sv =====
`default_nettype none

package tlsc_pkg;

    // Field widths fixed by the item formats
    localparam int COORD_W = 5;
    localparam int MAG_W   = 4;
    localparam int CELL_W  = 2 * COORD_W;
    // Manhattan index of a cell along a walk, up to 2*15
    localparam int IDX_W   = 5;
    // Error terms in tenths of a cell: up to 10*15*15 + 7*15
    localparam int ERR_W   = 12;

    localparam int MAX_DELTA_DEF        = 15;
    localparam int LINE_STORE_DEPTH_DEF = 32;

    // Distances in tenths of a cell
    localparam int HALF_CELL = 5;
    localparam int ONE_CELL  = 10;
    localparam int Y_NEAR    = 3;
    localparam int Y_FAR     = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [MAG_W-1:0]          ax;
        logic [MAG_W-1:0]          ay;
        logic [ERR_W-1:0]          ty0;
    } t_line_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/tlsc_in_if.sv =====
`default_nettype none

interface tlsc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tlsc_pkg::COORD_W-1:0]    delta_x;
    logic signed [tlsc_pkg::COORD_W-1:0]    delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlsc_out_if.sv =====
`default_nettype none

interface tlsc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tlsc_pkg::COORD_W-1:0]    cell_x;
    logic signed [tlsc_pkg::COORD_W-1:0]    cell_y;
    logic                                   last_cell;

    modport source (output valid, output cell_x, output cell_y, output last_cell,
                    input ready);
    modport sink   (input valid, input cell_x, input cell_y, input last_cell,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlsc_ram.sv =====
`default_nettype none

module tlsc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/tlsc_walker.sv =====
`default_nettype none

// One supercover step per cycle while a step is requested; a corner crossing is taken as an x step, then a y step.
module tlsc_walker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tlsc_pkg::t_walk_ctl                 i_ctl,
    input  wire tlsc_pkg::t_line_cfg                 i_cfg,
    output logic signed [tlsc_pkg::COORD_W-1:0]      o_x,
    output logic signed [tlsc_pkg::COORD_W-1:0]      o_y,
    output logic        [tlsc_pkg::IDX_W-1:0]        o_idx,
    output logic                                     o_at_end
);

    logic signed [tlsc_pkg::COORD_W-1:0] r_x;
    logic signed [tlsc_pkg::COORD_W-1:0] r_y;
    logic [tlsc_pkg::IDX_W-1:0]          r_idx;
    logic [tlsc_pkg::ERR_W-1:0]          r_tx;
    logic [tlsc_pkg::ERR_W-1:0]          r_ty;
    logic                                r_pend_y;

    logic x_none, y_none, take_x, take_y, step_x, n_pend_y;
    logic [tlsc_pkg::ERR_W-1:0] inc_x, inc_y, tx0;

    always_comb begin
        x_none   = (i_cfg.ax == '0);
        y_none   = (i_cfg.ay == '0);
        take_x   = !x_none && (y_none || (r_tx < r_ty));
        take_y   = !y_none && (x_none || (r_ty < r_tx));
        // pending y step of a corner goes first
        step_x   = !r_pend_y && (take_x || !take_y);
        n_pend_y = step_x && (take_y || !take_x);
        inc_x    = tlsc_pkg::ERR_W'(i_cfg.ay) * tlsc_pkg::ERR_W'(tlsc_pkg::ONE_CELL);
        inc_y    = tlsc_pkg::ERR_W'(i_cfg.ax) * tlsc_pkg::ERR_W'(tlsc_pkg::ONE_CELL);
        tx0      = tlsc_pkg::ERR_W'(i_cfg.ay) * tlsc_pkg::ERR_W'(tlsc_pkg::HALF_CELL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_y <= 1'b0;
        end else if (i_ctl.load) begin
            r_pend_y <= 1'b0;
        end else if (i_ctl.step) begin
            r_pend_y <= n_pend_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= '0;
            r_y   <= '0;
            r_idx <= '0;
            r_tx  <= tx0;
            r_ty  <= i_cfg.ty0;
        end else if (i_ctl.step) begin
            r_idx <= r_idx + 1'b1;
            if (step_x) begin
                r_x  <= i_cfg.dx[tlsc_pkg::COORD_W-1] ? r_x - 5'sd1 : r_x + 5'sd1;
                r_tx <= r_tx + inc_x;
            end else begin
                r_y  <= i_cfg.dy[tlsc_pkg::COORD_W-1] ? r_y - 5'sd1 : r_y + 5'sd1;
                r_ty <= r_ty + inc_y;
            end
        end
    end

    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_idx    = r_idx;
    assign o_at_end = (r_x == i_cfg.dx) && (r_y == i_cfg.dy) && !r_pend_y;

endmodule

`default_nettype wire

// ===== hw/rtl/thick_line_supercover_cells.sv =====
`default_nettype none

// Thick supercover line cells. Each input item is a signed displacement
// (delta_x, delta_y), saturated to +/-MAX_DELTA. The block walks two supercover
// lines from the origin cell to the end cell, one 0.2 cell above the center
// line and one 0.2 cell below, and returns the covered cells as a run of items:
// all cells of the upper line in walk order, then the cells of the lower line
// that the upper line did not already cover. last_cell marks the final item of
// a run; a zero displacement gives the single cell (0,0). At a corner crossing
// the x-step cell comes before the y-step cell. Edge crossings are decided with
// exact integer error terms in tenths of a cell. Only the first
// LINE_STORE_DEPTH cells of the upper line are remembered for the overlap test.
// Timing: one walker step unit produces one cell per cycle while the output
// side does not stall, and is shared by both lines. An item passes through
// idle, setup, two walks of |dx|+|dy|+1 cells, a drain of the compare stage
// and a flush for the last cell.
// Input ready is high only while the block is idle; a stall on the output
// freezes the walk. The line store needs no clearing after reset.
module thick_line_supercover_cells #(
    parameter int MAX_DELTA        = tlsc_pkg::MAX_DELTA_DEF,
    parameter int LINE_STORE_DEPTH = tlsc_pkg::LINE_STORE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tlsc_in_if.sink     i_in,
    tlsc_out_if.source  o_out
);

    localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);
    localparam int CMP_W  = ((ADDR_W > tlsc_pkg::IDX_W) ? ADDR_W : tlsc_pkg::IDX_W) + 1;
    localparam logic signed [tlsc_pkg::COORD_W-1:0] MAX_V = tlsc_pkg::COORD_W'(MAX_DELTA);

    // control
    tlsc_pkg::t_state r_state, n_state;
    logic r_line;        // 0: upper line, 1: lower line
    logic r_wk_on;       // walker holds a cell still to be issued

    // displacement after saturation
    logic signed [tlsc_pkg::COORD_W-1:0] r_dx, r_dy;

    // compare stage
    logic                                r_s1_v;
    logic                                r_s1_chk;
    logic signed [tlsc_pkg::COORD_W-1:0] r_s1_x, r_s1_y;

    // pending cell: held until it is known whether it is the last one
    logic                                r_pd_v;
    logic signed [tlsc_pkg::COORD_W-1:0] r_pd_x, r_pd_y;

    // output register
    logic                                r_ov;
    logic                                r_olast;
    logic signed [tlsc_pkg::COORD_W-1:0] r_ox, r_oy;

    // FSM outputs
    logic w_in_ready, w_setup, w_walk, w_flush;

    logic signed [tlsc_pkg::COORD_W-1:0] sat_dx, sat_dy;
    logic [tlsc_pkg::MAG_W-1:0]          ax, ay;
    logic                                dy_pos, near_first;
    tlsc_pkg::t_line_cfg                 cfg;
    tlsc_pkg::t_walk_ctl                 ctl;

    logic signed [tlsc_pkg::COORD_W-1:0] w_x, w_y;
    logic [tlsc_pkg::IDX_W-1:0]          w_idx;
    logic                                w_at_end;

    logic                                adv, emit, in_store, kept;
    logic [tlsc_pkg::CELL_W-1:0]         rd_cell;

    // saturation of the incoming displacement
    always_comb begin
        if (i_in.delta_x > MAX_V) begin
            sat_dx = MAX_V;
        end else if (i_in.delta_x < -MAX_V) begin
            sat_dx = -MAX_V;
        end else begin
            sat_dx = i_in.delta_x;
        end
        if (i_in.delta_y > MAX_V) begin
            sat_dy = MAX_V;
        end else if (i_in.delta_y < -MAX_V) begin
            sat_dy = -MAX_V;
        end else begin
            sat_dy = i_in.delta_y;
        end
    end

    // line parameters; the upper line is loaded in SETUP, the lower one at the switch
    always_comb begin
        ax         = r_dx[tlsc_pkg::COORD_W-1] ? tlsc_pkg::MAG_W'(-r_dx)
                                               : tlsc_pkg::MAG_W'(r_dx);
        ay         = r_dy[tlsc_pkg::COORD_W-1] ? tlsc_pkg::MAG_W'(-r_dy)
                                               : tlsc_pkg::MAG_W'(r_dy);
        dy_pos     = !r_dy[tlsc_pkg::COORD_W-1] && (r_dy != '0);
        // first y edge is 0.3 away when the offset line is on the side of travel
        near_first = dy_pos ^ !w_setup;
        cfg.dx     = r_dx;
        cfg.dy     = r_dy;
        cfg.ax     = ax;
        cfg.ay     = ay;
        cfg.ty0    = tlsc_pkg::ERR_W'(ax) * (near_first
                   ? tlsc_pkg::ERR_W'(tlsc_pkg::Y_NEAR)
                   : tlsc_pkg::ERR_W'(tlsc_pkg::Y_FAR));
    end

    // the whole pipe moves only when the output register can take an item
    always_comb begin
        adv      = !r_ov || o_out.ready;
        emit     = w_walk && r_wk_on && adv;
        in_store = (CMP_W'(w_idx) < CMP_W'(LINE_STORE_DEPTH));
        ctl.load = w_setup || (emit && w_at_end && !r_line);
        ctl.step = emit && !w_at_end;
        // cell index along the walk equals |x|+|y|, so entry idx of the upper
        // line is the only candidate match for a lower-line cell
        kept     = r_s1_v && (!r_s1_chk || (rd_cell != {r_s1_x, r_s1_y}));
    end

    tlsc_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .o_x      (w_x),
        .o_y      (w_y),
        .o_idx    (w_idx),
        .o_at_end (w_at_end)
    );

    tlsc_ram #(
        .WIDTH (tlsc_pkg::CELL_W),
        .DEPTH (LINE_STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (emit && !r_line && in_store),
        .i_waddr (ADDR_W'(w_idx)),
        .i_wdata ({w_x, w_y}),
        .i_re    (emit && r_line),
        .i_raddr (ADDR_W'(w_idx)),
        .o_rdata (rd_cell)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlsc_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = tlsc_pkg::ST_SETUP;
                end
            end
            tlsc_pkg::ST_SETUP: begin
                n_state = tlsc_pkg::ST_WALK;
            end
            tlsc_pkg::ST_WALK: begin
                if (!r_wk_on && !r_s1_v) begin
                    n_state = tlsc_pkg::ST_FLUSH;
                end
            end
            tlsc_pkg::ST_FLUSH: begin
                if (adv) begin
                    n_state = tlsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlsc_pkg::ST_IDLE;
            end
        endcase
    end

    // state decode
    always_comb begin
        w_in_ready = 1'b0;
        w_setup    = 1'b0;
        w_walk     = 1'b0;
        w_flush    = 1'b0;
        case (r_state)
            tlsc_pkg::ST_IDLE:  w_in_ready = 1'b1;
            tlsc_pkg::ST_SETUP: w_setup    = 1'b1;
            tlsc_pkg::ST_WALK:  w_walk     = 1'b1;
            tlsc_pkg::ST_FLUSH: w_flush    = adv;
            default:            w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlsc_pkg::ST_IDLE;
            r_line  <= 1'b0;
            r_wk_on <= 1'b0;
            r_s1_v  <= 1'b0;
            r_pd_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_setup) begin
                r_line  <= 1'b0;
                r_wk_on <= 1'b1;
            end else if (emit && w_at_end) begin
                if (r_line) begin
                    r_wk_on <= 1'b0;
                end else begin
                    r_line <= 1'b1;
                end
            end

            if (adv) begin
                r_s1_v <= emit;
                if (kept) begin
                    r_pd_v <= 1'b1;
                end else if (w_flush) begin
                    r_pd_v <= 1'b0;
                end
                r_ov <= (kept && r_pd_v) || w_flush;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_dx <= sat_dx;
            r_dy <= sat_dy;
        end
        if (adv) begin
            r_s1_x   <= w_x;
            r_s1_y   <= w_y;
            r_s1_chk <= r_line && in_store;
            if (kept) begin
                r_pd_x <= r_s1_x;
                r_pd_y <= r_s1_y;
            end
            if ((kept && r_pd_v) || w_flush) begin
                r_ox    <= r_pd_x;
                r_oy    <= r_pd_y;
                r_olast <= w_flush;
            end
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_ov;
    assign o_out.cell_x    = r_ox;
    assign o_out.cell_y    = r_oy;
    assign o_out.last_cell = r_olast;

endmodule

`default_nettype wire
